// ===== hw/rtl/css_easing_curve_evaluator_top_assert.svh =====
// Assertion macros for the easing curve evaluator.
// Both use i_clk of the module they stand in; CEE_ASSERT also uses its i_rst_n.
`ifndef CSS_EASING_CURVE_EVALUATOR_TOP_ASSERT_SVH
`define CSS_EASING_CURVE_EVALUATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CEE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cee: assertion failed");
`define CEE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("cee: reset assertion failed");
`else
`define CEE_ASSERT(lbl, prop)
`define CEE_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== hw/rtl/cee_pkg.sv =====
package cee_pkg;

    localparam int FRAC_BITS             = 16;
    localparam int NEWTON_ITERATIONS_DEF = 8;

    // internal signed Q format, holds -16.0 up to just under +16.0
    localparam int QW = FRAC_BITS + 5;

    localparam int PROG_W     = 19;
    localparam int EASE_W     = 19;
    localparam int MODE_W     = 4;
    localparam int CX_W       = 17;
    localparam int CY_W       = 19;
    localparam int STEP_W     = 10;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    typedef logic signed [QW-1:0] t_q;

    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam t_q ONE    = t_q'(ONE_L);
    localparam t_q ZERO   = t_q'(0);
    localparam t_q P10    = t_q'((10 * ONE_L + 50) / 100);
    localparam t_q P25    = t_q'((25 * ONE_L + 50) / 100);
    localparam t_q P42    = t_q'((42 * ONE_L + 50) / 100);
    localparam t_q P58    = t_q'((58 * ONE_L + 50) / 100);
    localparam t_q SAT_LO = t_q'(-2 * ONE_L);
    localparam t_q SAT_HI = t_q'(3 * ONE_L);

    // Newton quotient divider: |x - t| << F over |dx|, saturating quotient
    localparam int NDIV_NW = QW - 1 + FRAC_BITS;
    localparam int NDIV_DW = QW - 1;
    localparam int NDIV_QB = FRAC_BITS + 2;
    // steps divider: k << F over n, quotient never above one when n is nonzero
    localparam int SDIV_NW = FRAC_BITS + STEP_W;
    localparam int SDIV_DW = STEP_W;
    localparam int SDIV_QB = FRAC_BITS + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR      = 4'd0,
        MODE_EASE        = 4'd1,
        MODE_EASE_IN     = 4'd2,
        MODE_EASE_OUT    = 4'd3,
        MODE_EASE_IN_OUT = 4'd4,
        MODE_CUSTOM      = 4'd5,
        MODE_STEP_START  = 4'd6,
        MODE_STEP_END    = 4'd7,
        MODE_STEPS       = 4'd8
    } t_mode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_X1    = 3'd1,
        REG_Y1    = 3'd2,
        REG_X2    = 3'd3,
        REG_Y2    = 3'd4,
        REG_STEPS = 3'd5,
        REG_JUMP  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_q   t;        // clamped progress
        t_q   g;        // current Newton guess
        t_q   fix;      // result for non-bezier modes
        logic bez;
        logic use_div;
    } t_item;

    typedef struct packed {
        t_item item;
        logic  neg;
        logic  zero;
    } t_nwt_side;

    // product scaled by 2^-F, rounded toward minus infinity
    function automatic t_q qmul(t_q a, t_q b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return p[FRAC_BITS+QW-1:FRAC_BITS];
    endfunction

endpackage

// ===== hw/rtl/cee_ifs.sv =====
interface cee_prog_if import cee_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [PROG_W-1:0] progress;
    modport source (output valid, output progress, input ready);
    modport sink   (input valid, input progress, output ready);
endinterface

interface cee_ease_if import cee_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [EASE_W-1:0] eased_value;
    modport source (output valid, output eased_value, input ready);
    modport sink   (input valid, input eased_value, output ready);
endinterface

interface cee_cfg_if import cee_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/cee_div_pipe.sv =====
// Restoring divider, one quotient bit per stage. Quotient saturates to all
// ones when it would not fit in QB bits.
module cee_div_pipe import cee_pkg::*; #(
    parameter int NW  = SDIV_NW,
    parameter int DW  = SDIV_DW,
    parameter int QB  = SDIV_QB,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic [QB-1:0]  o_quot,
    output logic [SBW-1:0] o_side
);
    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic           r_v    [0:QB];
    logic [QB-1:0]  r_q    [0:QB];
    logic           r_ovf  [0:QB];
    logic [SBW-1:0] r_side [0:QB];
    logic [CW-1:0]  r_rem  [0:QB-1];
    logic [DW-1:0]  r_den  [0:QB-1];

    logic [CW:0]    w_trial [1:QB];
    logic [QB-1:0]  n_q     [1:QB];
    logic [CW-1:0]  n_rem   [1:QB-1];
    logic           w_ovf;

    assign w_ovf = CW'(i_num) >= (CW'(i_den) << QB);

    always_comb begin
        for (int s = 1; s <= QB; s++) begin
            w_trial[s] = {1'b0, r_rem[s-1]} - ({1'b0, CW'(r_den[s-1])} << (QB - s));
            n_q[s] = r_q[s-1];
            n_q[s][QB-s] = !w_trial[s][CW];
        end
        for (int s = 1; s < QB; s++) begin
            n_rem[s] = w_trial[s][CW] ? r_rem[s-1] : w_trial[s][CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= QB; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= CW'(i_num);
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= w_ovf;
            r_side[0] <= i_side;
            for (int s = 1; s <= QB; s++) begin
                r_q[s]    <= n_q[s];
                r_ovf[s]  <= r_ovf[s-1];
                r_side[s] <= r_side[s-1];
            end
            for (int s = 1; s < QB; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= r_den[s-1];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_quot  = r_ovf[QB] ? '1 : r_q[QB];
    assign o_side  = r_side[QB];

endmodule

// ===== hw/rtl/cee_bez_eval.sv =====
// Three-stage cubic Bezier evaluation at g for inner points p1, p2:
// poly = B(g), deriv = B'(g).
module cee_bez_eval import cee_pkg::*; #(
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_q             i_g,
    input  t_q             i_p1,
    input  t_q             i_p2,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output t_q             o_poly,
    output t_q             o_deriv,
    output logic [SBW-1:0] o_side
);
    logic           r1_v, r2_v, r3_v;
    t_q             r1_g, r1_oo, r1_og, r1_gg;
    t_q             r2_a, r2_b, r2_c, r2_da, r2_db, r2_dc;
    t_q             r3_poly, r3_d;
    logic [SBW-1:0] r1_side, r2_side, r3_side;
    t_q             w_omg, w_pa, w_pb;

    assign w_omg = ONE - i_g;
    assign w_pa  = qmul(r2_a, i_p1);
    assign w_pb  = qmul(r2_b, i_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_g    <= i_g;
            r1_oo   <= qmul(w_omg, w_omg);
            r1_og   <= qmul(w_omg, i_g);
            r1_gg   <= qmul(i_g, i_g);
            r1_side <= i_side;

            r2_a    <= qmul(r1_oo, r1_g);
            r2_b    <= qmul(r1_og, r1_g);
            r2_c    <= qmul(r1_gg, r1_g);
            r2_da   <= qmul(r1_oo, i_p1);
            r2_db   <= qmul(r1_og, i_p2 - i_p1);
            r2_dc   <= qmul(r1_gg, ONE - i_p2);
            r2_side <= r1_side;

            r3_poly <= (w_pa <<< 1) + w_pa + (w_pb <<< 1) + w_pb + r2_c;
            r3_d    <= (r2_da <<< 1) + r2_da + (r2_db <<< 2) + (r2_db <<< 1)
                     + (r2_dc <<< 1) + r2_dc;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r3_v;
    assign o_poly  = r3_poly;
    assign o_deriv = r3_d;
    assign o_side  = r3_side;

endmodule

// ===== hw/rtl/cee_newton.sv =====
// One Newton step on x(g) = t: evaluate, form the step, divide, clamp.
module cee_newton import cee_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    input  t_q    i_x1,
    input  t_q    i_x2,
    output logic  o_valid,
    output t_item o_item
);
    localparam int IW = $bits(t_item);
    localparam int NSW = $bits(t_nwt_side);

    logic                ev_v;
    t_q                  ev_poly, ev_d;
    logic [IW-1:0]       ev_side;
    t_item               w_it;
    t_q                  w_diff, w_adiff, w_ad;

    logic                r_p_v;
    logic [NDIV_NW-1:0]  r_p_num;
    logic [NDIV_DW-1:0]  r_p_den;
    t_nwt_side           r_p_side;

    logic                dv_v;
    logic [NDIV_QB-1:0]  dv_q;
    logic [NSW-1:0]      dv_side;
    t_nwt_side           w_sd;
    t_q                  w_qs, w_gn;
    t_item               n_item;

    logic                r_u_v;
    t_item               r_u_item;

    cee_bez_eval #(.SBW(IW)) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_g     (i_item.g),
        .i_p1    (i_x1),
        .i_p2    (i_x2),
        .i_side  (i_item),
        .o_valid (ev_v),
        .o_poly  (ev_poly),
        .o_deriv (ev_d),
        .o_side  (ev_side)
    );

    assign w_it    = t_item'(ev_side);
    assign w_diff  = ev_poly - w_it.t;
    assign w_adiff = w_diff[QW-1] ? -w_diff : w_diff;
    assign w_ad    = ev_d[QW-1] ? -ev_d : ev_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_v <= 1'b0;
        else if (i_en) r_p_v <= ev_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_num       <= {w_adiff[QW-2:0], {FRAC_BITS{1'b0}}};
            r_p_den       <= w_ad[QW-2:0];
            r_p_side.item <= w_it;
            r_p_side.neg  <= w_diff[QW-1] ^ ev_d[QW-1];
            r_p_side.zero <= (ev_d == ZERO);
        end
    end

    cee_div_pipe #(
        .NW  (NDIV_NW),
        .DW  (NDIV_DW),
        .QB  (NDIV_QB),
        .SBW (NSW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_p_v),
        .i_num   (r_p_num),
        .i_den   (r_p_den),
        .i_side  (r_p_side),
        .o_valid (dv_v),
        .o_quot  (dv_q),
        .o_side  (dv_side)
    );

    // quotient is truncated toward zero: magnitude divide, then sign
    always_comb begin
        w_sd   = t_nwt_side'(dv_side);
        w_qs   = t_q'(dv_q);
        w_gn   = w_sd.neg ? w_sd.item.g + w_qs : w_sd.item.g - w_qs;
        n_item = w_sd.item;
        if (!w_sd.zero) begin
            if (w_gn < ZERO) n_item.g = ZERO;
            else if (w_gn > ONE) n_item.g = ONE;
            else n_item.g = w_gn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_u_v <= 1'b0;
        else if (i_en) r_u_v <= dv_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_u_item <= n_item;
    end

    assign o_valid = r_u_v;
    assign o_item  = r_u_item;

endmodule

// ===== hw/rtl/css_easing_curve_evaluator_top.sv =====
// Each Newton step costs a 3-stage curve evaluation, a prep stage, a one-bit-per-stage
// divider and an update stage; the steps divider runs ahead of the Newton chain.
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module css_easing_curve_evaluator_top import cee_pkg::*; #(
    parameter int NEWTON_ITERATIONS = NEWTON_ITERATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cee_prog_if.sink    i_prog,
    cee_ease_if.source  o_ease,
    cee_cfg_if.sink     i_cfg
);
`include "css_easing_curve_evaluator_top_assert.svh"

    localparam int PW = FRAC_BITS + 1 + STEP_W;
    localparam int IW = $bits(t_item);
    localparam logic signed [EASE_W-1:0] OUT_LO = EASE_W'(SAT_LO);
    localparam logic signed [EASE_W-1:0] OUT_HI = EASE_W'(SAT_HI);

    // configuration
    t_mode                   r_mode;
    logic [CX_W-1:0]         r_x1, r_x2;
    logic signed [CY_W-1:0]  r_y1, r_y2;
    logic [STEP_W-1:0]       r_steps;
    logic                    r_jump;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LINEAR;
            r_x1    <= '0;
            r_y1    <= '0;
            r_x2    <= CX_W'(ONE);
            r_y2    <= CY_W'(ONE);
            r_steps <= STEP_W'(1);
            r_jump  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_MODE:  r_mode  <= t_mode'(i_cfg.data[MODE_W-1:0]);
                REG_X1:    r_x1    <= i_cfg.data[CX_W-1:0];
                REG_Y1:    r_y1    <= signed'(i_cfg.data[CY_W-1:0]);
                REG_X2:    r_x2    <= i_cfg.data[CX_W-1:0];
                REG_Y2:    r_y2    <= signed'(i_cfg.data[CY_W-1:0]);
                REG_STEPS: r_steps <= i_cfg.data[STEP_W-1:0];
                REG_JUMP:  r_jump  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // control points for the selected curve
    t_q   w_px1, w_py1, w_px2, w_py2, w_cx1, w_cx2;
    logic w_ident;

    assign w_cx1 = (t_q'(r_x1) > ONE) ? ONE : t_q'(r_x1);
    assign w_cx2 = (t_q'(r_x2) > ONE) ? ONE : t_q'(r_x2);

    always_comb begin
        case (r_mode)
            MODE_EASE: begin
                w_px1 = P25;  w_py1 = P10;  w_px2 = P25;  w_py2 = ONE;
            end
            MODE_EASE_IN: begin
                w_px1 = P42;  w_py1 = ZERO; w_px2 = ONE;  w_py2 = ONE;
            end
            MODE_EASE_OUT: begin
                w_px1 = ZERO; w_py1 = ZERO; w_px2 = P58;  w_py2 = ONE;
            end
            MODE_EASE_IN_OUT: begin
                w_px1 = P42;  w_py1 = ZERO; w_px2 = P58;  w_py2 = ONE;
            end
            MODE_CUSTOM: begin
                w_px1 = w_cx1; w_py1 = t_q'(r_y1); w_px2 = w_cx2; w_py2 = t_q'(r_y2);
            end
            default: begin
                w_px1 = ZERO; w_py1 = ZERO; w_px2 = ONE;  w_py2 = ONE;
            end
        endcase
    end

    assign w_ident = (w_px1 == ZERO) && (w_py1 == ZERO) && (w_px2 == ONE) && (w_py2 == ONE);

    // global advance: the pipeline moves whenever the output register can take a word
    logic r_out_valid;
    logic w_en;

    assign w_en         = !r_out_valid || o_ease.ready;
    assign i_prog.ready = w_en;

    // front stage: clamp, mode decode, steps product
    t_q      w_pr, w_tc;
    t_item   n_f_item;
    logic [PW-1:0] w_prod;

    logic          r_f_v;
    t_item         r_f_item;
    logic [PW-1:0] r_f_prod;

    assign w_pr = t_q'(i_prog.progress);
    assign w_tc = (w_pr < ZERO) ? ZERO : ((w_pr > ONE) ? ONE : w_pr);
    assign w_prod = PW'(w_tc[FRAC_BITS:0]) * PW'(r_steps)
                  + (r_jump ? PW'(ONE_L - 1) : PW'(0));

    always_comb begin
        n_f_item.t       = w_tc;
        n_f_item.g       = w_tc;
        n_f_item.bez     = 1'b0;
        n_f_item.use_div = 1'b0;
        n_f_item.fix     = w_tc;
        case (r_mode)
            MODE_EASE, MODE_EASE_IN, MODE_EASE_OUT, MODE_EASE_IN_OUT, MODE_CUSTOM:
                n_f_item.bez = 1'b1;
            MODE_STEP_START: n_f_item.fix = (w_tc > ZERO) ? ONE : ZERO;
            MODE_STEP_END:   n_f_item.fix = (w_tc >= ONE) ? ONE : ZERO;
            MODE_STEPS:      n_f_item.use_div = (r_steps != '0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_v <= 1'b0;
        else if (w_en) r_f_v <= i_prog.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_item <= n_f_item;
            r_f_prod <= w_prod;
        end
    end

    // steps: k * ONE / n
    logic               sd_v;
    logic [SDIV_QB-1:0] sd_q;
    logic [IW-1:0]      sd_side;

    cee_div_pipe #(
        .NW  (SDIV_NW),
        .DW  (SDIV_DW),
        .QB  (SDIV_QB),
        .SBW (IW)
    ) u_step_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f_v),
        .i_num   ({r_f_prod[FRAC_BITS+STEP_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}}),
        .i_den   (r_steps),
        .i_side  (r_f_item),
        .o_valid (sd_v),
        .o_quot  (sd_q),
        .o_side  (sd_side)
    );

    // Newton chain
    logic  w_nv [0:NEWTON_ITERATIONS];
    t_item w_ni [0:NEWTON_ITERATIONS];

    always_comb begin
        w_ni[0] = t_item'(sd_side);
        if (w_ni[0].use_div) w_ni[0].fix = t_q'(sd_q);
    end
    assign w_nv[0] = sd_v;

    for (genvar i = 0; i < NEWTON_ITERATIONS; i++) begin : g_newton
        cee_newton u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_nv[i]),
            .i_item  (w_ni[i]),
            .i_x1    (w_px1),
            .i_x2    (w_px2),
            .o_valid (w_nv[i+1]),
            .o_item  (w_ni[i+1])
        );
    end

    // y at the solved parameter
    logic          y_v;
    t_q            y_val;
    logic [IW-1:0] y_side;
    t_item         w_yi;
    t_q            w_res, w_sat;

    cee_bez_eval #(.SBW(IW)) u_y_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_nv[NEWTON_ITERATIONS]),
        .i_g     (w_ni[NEWTON_ITERATIONS].g),
        .i_p1    (w_py1),
        .i_p2    (w_py2),
        .i_side  (w_ni[NEWTON_ITERATIONS]),
        .o_valid (y_v),
        .o_poly  (y_val),
        .o_deriv (),
        .o_side  (y_side)
    );

    always_comb begin
        w_yi = t_item'(y_side);
        if (!w_yi.bez) w_res = w_yi.fix;
        else if (w_yi.t == ZERO) w_res = ZERO;
        else if (w_yi.t == ONE) w_res = ONE;
        else if (w_ident) w_res = w_yi.t;
        else w_res = y_val;
        if (w_res < SAT_LO) w_sat = SAT_LO;
        else if (w_res > SAT_HI) w_sat = SAT_HI;
        else w_sat = w_res;
    end

    logic signed [EASE_W-1:0] r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_en) r_out_valid <= y_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_out_val <= EASE_W'(w_sat);
    end

    assign o_ease.valid       = r_out_valid;
    assign o_ease.eased_value = r_out_val;

    `CEE_ASSERT_RST(a_rst_empties_out, !i_rst_n |=> !o_ease.valid)
    `CEE_ASSERT(a_out_in_range, o_ease.valid |-> (o_ease.eased_value >= OUT_LO && o_ease.eased_value <= OUT_HI))
    `CEE_ASSERT(a_ready_when_empty, !o_ease.valid |-> i_prog.ready)

endmodule

// ===== tb/sv/tb_css_easing_curve_evaluator_top.sv =====
`timescale 1ns / 1ps

module tb_css_easing_curve_evaluator_top;
    import cee_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    cee_prog_if prog_if ();
    cee_ease_if ease_if ();
    cee_cfg_if  cfg_if ();

    css_easing_curve_evaluator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prog  (prog_if.sink),
        .o_ease  (ease_if.source),
        .i_cfg   (cfg_if.sink)
    );

    localparam longint Q1 = longint'(1) << FRAC_BITS;
    localparam int LATENCY = 7 + FRAC_BITS + NEWTON_ITERATIONS_DEF * (FRAC_BITS + 8);
    localparam longint CYCLE_LIMIT = 3000000;

    // shadow copy of the block's registers
    logic [MODE_W-1:0] cur_mode;
    logic [CX_W-1:0]   cur_x1, cur_x2;
    logic [CY_W-1:0]   cur_y1, cur_y2;
    logic [STEP_W-1:0] cur_steps;
    logic              cur_jump;

    logic [PROG_W-1:0] progress_q[$];
    logic [EASE_W-1:0] eased_q[$];
    int   send_idle_pct = 17;
    int   recv_idle_pct = 71;
    int   n_checked = 0;
    int   n_errors  = 0;
    longint cycles  = 0;

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint cubic_at(longint g, longint p1, longint p2);
        longint omg;
        omg = Q1 - g;
        return 3 * fx_mul(fx_mul(fx_mul(omg, omg), g), p1)
             + 3 * fx_mul(fx_mul(fx_mul(omg, g), g), p2)
             + fx_mul(fx_mul(g, g), g);
    endfunction

    function automatic longint pct(longint n);
        return (n * Q1 + 50) / 100;
    endfunction

    function automatic longint solve_bezier(longint t, longint x1, longint y1,
                                            longint x2, longint y2);
        longint g, omg, x, dx;
        g = t;
        if (t <= 0) return 0;
        if (t >= Q1) return Q1;
        if (x1 == 0 && y1 == 0 && x2 == Q1 && y2 == Q1) return t;
        for (int i = 0; i < NEWTON_ITERATIONS_DEF; i++) begin
            omg = Q1 - g;
            x = cubic_at(g, x1, x2);
            dx = 3 * fx_mul(fx_mul(omg, omg), x1)
               + 6 * fx_mul(fx_mul(omg, g), x2 - x1)
               + 3 * fx_mul(fx_mul(g, g), Q1 - x2);
            if (dx == 0) break;
            g = g - ((x - t) * Q1) / dx;
            if (g < 0) g = 0;
            if (g > Q1) g = Q1;
        end
        return cubic_at(g, y1, y2);
    endfunction

    function automatic logic [EASE_W-1:0] eased_of(logic [PROG_W-1:0] p);
        longint t, r, n, k, cx1, cx2;
        t = longint'($signed(p));
        if (t < 0) t = 0;
        if (t > Q1) t = Q1;
        n = longint'(cur_steps);
        cx1 = (longint'(cur_x1) > Q1) ? Q1 : longint'(cur_x1);
        cx2 = (longint'(cur_x2) > Q1) ? Q1 : longint'(cur_x2);
        case (cur_mode)
            MODE_EASE:        r = solve_bezier(t, pct(25), pct(10), pct(25), Q1);
            MODE_EASE_IN:     r = solve_bezier(t, pct(42), 0, Q1, Q1);
            MODE_EASE_OUT:    r = solve_bezier(t, 0, 0, pct(58), Q1);
            MODE_EASE_IN_OUT: r = solve_bezier(t, pct(42), 0, pct(58), Q1);
            MODE_CUSTOM:      r = solve_bezier(t, cx1, longint'($signed(cur_y1)), cx2,
                                               longint'($signed(cur_y2)));
            MODE_STEP_START:  r = (t > 0) ? Q1 : 0;
            MODE_STEP_END:    r = (t >= Q1) ? Q1 : 0;
            MODE_STEPS: begin
                if (n == 0) begin
                    r = t;
                end else begin
                    k = cur_jump ? (t * n + Q1 - 1) >>> FRAC_BITS : (t * n) >>> FRAC_BITS;
                    r = (k * Q1) / n;
                end
            end
            default:          r = t;
        endcase
        if (r < -2 * Q1) r = -2 * Q1;
        if (r > 3 * Q1) r = 3 * Q1;
        return r[EASE_W-1:0];
    endfunction

    // driver: one word per handshake, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prog_if.valid <= 1'b0;
            prog_if.progress <= '0;
        end else if (!prog_if.valid || prog_if.ready) begin
            if (progress_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                prog_if.valid <= 1'b1;
                prog_if.progress <= progress_q[0];
                eased_q.push_back(eased_of(progress_q[0]));
                void'(progress_q.pop_front());
            end else begin
                prog_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            ease_if.ready <= 1'b0;
        end else begin
            ease_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (ease_if.valid && ease_if.ready) begin
                if (eased_q.size() == 0) begin
                    $error("unexpected word: eased_value %0d", $signed(ease_if.eased_value));
                    n_errors++;
                end else begin
                    if (ease_if.eased_value !== eased_q[0]) begin
                        $error("eased_value: expected %0d, actual %0d",
                               $signed(eased_q[0]), $signed(ease_if.eased_value));
                        n_errors++;
                    end
                    void'(eased_q.pop_front());
                    n_checked++;
                end
            end
        end
    end

    initial begin
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_MODE:  cur_mode  = val[MODE_W-1:0];
            REG_X1:    cur_x1    = val[CX_W-1:0];
            REG_Y1:    cur_y1    = val[CY_W-1:0];
            REG_X2:    cur_x2    = val[CX_W-1:0];
            REG_Y2:    cur_y2    = val[CY_W-1:0];
            REG_STEPS: cur_steps = val[STEP_W-1:0];
            REG_JUMP:  cur_jump  = val[0];
            default: ;
        endcase
        // valid stays low between writes
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (progress_q.size() != 0 || eased_q.size() != 0 || prog_if.valid)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic logic [PROG_W-1:0] rand_progress();
        case ($urandom_range(9))
            0:       return PROG_W'(-$urandom_range(65536));
            1:       return PROG_W'(65536 + $urandom_range(65536));
            2:       return PROG_W'($urandom_range(1) ? 0 : 65536);
            3:       return PROG_W'($urandom);
            default: return PROG_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic rand_config();
        write_reg(REG_MODE, CFG_DATA_W'($urandom_range(9) == 0 ? $urandom_range(15)
                                                               : $urandom_range(8)));
        write_reg(REG_X1, CFG_DATA_W'($urandom_range(4) == 0 ? $urandom_range(131071)
                                                             : $urandom_range(65536)));
        write_reg(REG_Y1, CFG_DATA_W'(int'($urandom_range(327680)) - 131072));
        write_reg(REG_X2, CFG_DATA_W'($urandom_range(4) == 0 ? $urandom_range(131071)
                                                             : $urandom_range(65536)));
        write_reg(REG_Y2, CFG_DATA_W'(int'($urandom_range(327680)) - 131072));
        write_reg(REG_STEPS, CFG_DATA_W'($urandom_range(3) == 0 ? $urandom_range(1023)
                                                                : $urandom_range(12)));
        write_reg(REG_JUMP, CFG_DATA_W'($urandom_range(1)));
        // out-of-range index must be ignored
        if ($urandom_range(3) == 0)
            write_reg(t_reg_idx'(3'd7), CFG_DATA_W'($urandom));
    endtask

    task automatic directed_burst();
        logic [PROG_W-1:0] pts[12];
        pts = '{PROG_W'(-65536), PROG_W'(-1), 0, 1, 16384, 32768, 49152,
                65535, 65536, 65537, PROG_W'(131072), PROG_W'(262143)};
        foreach (pts[i]) progress_q.push_back(pts[i]);
    endtask

    initial begin
        cur_mode = 0; cur_x1 = 0; cur_y1 = 0; cur_x2 = 17'd65536; cur_y2 = 19'd65536;
        cur_steps = 1; cur_jump = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults, then each mode with corner settings
        directed_burst();
        drain();
        for (int m = 0; m <= 9; m++) begin
            write_reg(REG_MODE, CFG_DATA_W'(m == 9 ? 15 : m));
            write_reg(REG_STEPS, CFG_DATA_W'(m == 8 ? 0 : 1023));
            write_reg(REG_JUMP, CFG_DATA_W'(1));
            write_reg(REG_X1, 19'd131071);
            write_reg(REG_Y1, 19'h40000);
            write_reg(REG_X2, '0);
            write_reg(REG_Y2, 19'd196608);
            directed_burst();
            drain();
        end
        // identity bezier and flat-derivative custom curve
        write_reg(REG_MODE, CFG_DATA_W'(MODE_CUSTOM));
        write_reg(REG_X1, '0); write_reg(REG_Y1, '0);
        write_reg(REG_X2, 19'd65536); write_reg(REG_Y2, 19'd65536);
        directed_burst();
        drain();
        write_reg(REG_X1, 19'd65536); write_reg(REG_X2, '0);
        directed_burst();
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 71 : 0;
            recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 17 : 0;
            for (int s = 0; s < 6; s++) begin
                rand_config();
                repeat (89) progress_q.push_back(rand_progress());
                drain();
            end
        end

        $display("Covered all curve modes, unknown modes and register index, step corners");
        $display("and %0d checked words over many random register settings.", n_checked);
        if (n_errors == 0 && eased_q.size() == 0)
            $display("[css_easing_curve_evaluator_top] OK");
        else
            $display("[css_easing_curve_evaluator_top] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", eased_q.size());
            $display("[css_easing_curve_evaluator_top] ERROR");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cee_pkg.sv
hw/rtl/cee_ifs.sv
hw/rtl/cee_div_pipe.sv
hw/rtl/cee_bez_eval.sv
hw/rtl/cee_newton.sv
hw/rtl/css_easing_curve_evaluator_top.sv
tb/sv/tb_css_easing_curve_evaluator_top.sv
